[hw/rtl/ed_pkg.sv]
// shared types and constants of the elias delta stream codec
`default_nettype none
package ed_pkg;

    localparam int WORD_BITS = 32;
    localparam int BUF_BITS  = 4 * WORD_BITS;
    localparam int CNT_W     = $clog2(BUF_BITS) + 1;
    localparam int AMT_W     = $clog2(BUF_BITS);
    localparam int CODE_BITS = 42;
    localparam int LEN_W     = 6;
    localparam int KLEN_W    = 6;
    localparam int TDATA_W   = ((WORD_BITS + LEN_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENC_PUT,
        ST_ENC_WORD,
        ST_DEC_PUT,
        ST_DEC_STEP,
        ST_DRAIN
    } t_state;

    typedef enum logic [1:0] {
        DEC_WAIT,
        DEC_BAD,
        DEC_OK
    } t_dec;

    typedef struct packed {
        logic [WORD_BITS-1:0] data;
        logic                 last;
    } t_req;

    typedef struct packed {
        logic [WORD_BITS-1:0] data;
        logic [LEN_W-1:0]     bits;
        logic                 last;
        logic                 error;
    } t_res;

    typedef struct packed {
        t_dec                 kind;
        logic [WORD_BITS-1:0] val;
        logic [LEN_W-1:0]     len;
    } t_parse;

endpackage
`default_nettype wire

[hw/rtl/ed_shift.sv]
// shared 128-bit barrel shifter, left or right
`default_nettype none
module ed_shift (
    input  wire logic                       i_left,
    input  wire logic [ed_pkg::AMT_W-1:0]   i_amt,
    input  wire logic [ed_pkg::BUF_BITS-1:0] i_data,
    output logic      [ed_pkg::BUF_BITS-1:0] o_data
);
    import ed_pkg::*;

    logic [BUF_BITS-1:0] din;
    logic [BUF_BITS-1:0] din_rev;
    logic [BUF_BITS-1:0] shl;
    logic [BUF_BITS-1:0] shl_rev;

    // right shift runs through the same left shifter with the word mirrored
    always_comb begin
        for (int i = 0; i < BUF_BITS; i++) begin
            din_rev[i] = i_data[BUF_BITS-1-i];
        end
        din = i_left ? i_data : din_rev;
        shl = din << i_amt;
        for (int i = 0; i < BUF_BITS; i++) begin
            shl_rev[i] = shl[BUF_BITS-1-i];
        end
        o_data = i_left ? shl : shl_rev;
    end

endmodule
`default_nettype wire

[hw/rtl/ed_parse.sv]
// decode-side look at the head of the bit buffer: one code per cycle while results are taken
`default_nettype none
module ed_parse (
    input  wire logic [2*ed_pkg::WORD_BITS-1:0] i_top,
    input  wire logic [ed_pkg::CNT_W-1:0]       i_cnt,
    output ed_pkg::t_parse                      o_parse
);
    import ed_pkg::*;

    localparam int TOP_BITS = 2 * WORD_BITS;

    logic [2:0]          lz;
    logic [2:0]          p;
    logic [3:0]          hdr;
    logic [TOP_BITS-1:0] t;
    logic [TOP_BITS-1:0] u;
    logic [KLEN_W-1:0]   kf;
    logic [6:0]          len7;
    logic [WORD_BITS:0]  vext;

    always_comb begin
        // leading zeros of the top six bits, six when all are zero
        lz = 3'd6;
        for (int i = 5; i >= 0; i--) begin
            if (i_top[TOP_BITS-1-i]) begin
                lz = 3'(i);
            end
        end
        p    = lz + 3'd1;
        hdr  = {lz, 1'b1};
        t    = i_top << lz;
        kf   = t[TOP_BITS-1 -: KLEN_W] >> (3'd5 - lz);
        len7 = 7'({p, 1'b0}) + 7'(kf) - 7'd2;
        u    = i_top << hdr;
        vext = {1'b1, u[TOP_BITS-1 -: WORD_BITS]} >> (6'd33 - kf);

        o_parse.val  = vext[WORD_BITS-1:0];
        o_parse.len  = len7[LEN_W-1:0];
        o_parse.kind = DEC_WAIT;
        if (lz == 3'd6) begin
            if (i_cnt >= CNT_W'(6)) begin
                o_parse.kind = DEC_BAD;
            end
        end else if (CNT_W'(lz) >= i_cnt) begin
            o_parse.kind = DEC_WAIT;
        end else if (CNT_W'(hdr) > i_cnt) begin
            o_parse.kind = DEC_WAIT;
        end else if (kf > KLEN_W'(WORD_BITS)) begin
            o_parse.kind = DEC_BAD;
        end else if (CNT_W'(len7) > i_cnt) begin
            o_parse.kind = DEC_WAIT;
        end else begin
            o_parse.kind = DEC_OK;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/ed_core.sv]
// sequencer and bit buffer of the codec, one code or one word per step
`default_nettype none
module ed_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_clear,
    input  wire logic         i_dir,
    input  wire logic         i_req_valid,
    output logic              o_req_ready,
    input  wire ed_pkg::t_req i_req,
    output logic              o_res_valid,
    input  wire logic         i_res_ready,
    output ed_pkg::t_res      o_res
);
    import ed_pkg::*;

    t_state              r_state, n_state;
    logic [BUF_BITS-1:0] r_buf, n_buf;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_pend_valid, n_pend_valid;
    t_res                r_pend, n_pend;
    t_req                r_req, n_req;

    logic                sh_left;
    logic [AMT_W-1:0]    sh_amt;
    logic [BUF_BITS-1:0] sh_in;
    logic [BUF_BITS-1:0] sh_out;

    t_parse              parse;

    logic [KLEN_W-1:0]   enc_k;
    logic [2:0]          enc_p;
    logic [LEN_W-1:0]    enc_len;
    logic [CODE_BITS-1:0] enc_code;
    logic [CNT_W-1:0]    enc_sum;
    logic [AMT_W-1:0]    enc_amt;

    logic [CNT_W-1:0]    dec_cnt;
    logic [BUF_BITS-1:0] dec_buf;

    logic                prod;
    logic                can_prod;
    t_res                prod_res;

    ed_shift u_shift (
        .i_left (sh_left),
        .i_amt  (sh_amt),
        .i_data (sh_in),
        .o_data (sh_out)
    );

    ed_parse u_parse (
        .i_top   (r_buf[BUF_BITS-1 -: 2*WORD_BITS]),
        .i_cnt   (r_cnt),
        .o_parse (parse)
    );

    // encoder: bit lengths of the value and of its length, then the code
    always_comb begin
        enc_k = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (r_req.data[i]) begin
                enc_k = KLEN_W'(i + 1);
            end
        end
        enc_p = '0;
        for (int i = 0; i < KLEN_W; i++) begin
            if (enc_k[i]) begin
                enc_p = 3'(i + 1);
            end
        end
        enc_len  = {2'b00, enc_p, 1'b0} + enc_k - LEN_W'(2);
        enc_code = (CODE_BITS'(enc_k) << (enc_k - KLEN_W'(1)))
                 | (CODE_BITS'(r_req.data) & ~(CODE_BITS'(1) << (enc_k - KLEN_W'(1))));
        enc_sum  = r_cnt + CNT_W'(enc_len);
        enc_amt  = AMT_W'(CNT_W'(BUF_BITS) - enc_sum);
    end

    // an overfull buffer is dropped before the next word goes in
    always_comb begin
        if (r_cnt > CNT_W'(BUF_BITS - WORD_BITS)) begin
            dec_cnt = '0;
            dec_buf = '0;
        end else begin
            dec_cnt = r_cnt;
            dec_buf = r_buf;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_buf        = r_buf;
        n_cnt        = r_cnt;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_req        = r_req;
        sh_left      = 1'b1;
        sh_amt       = '0;
        sh_in        = r_buf;
        prod         = 1'b0;
        prod_res     = '0;
        o_req_ready  = 1'b0;
        o_res_valid  = 1'b0;
        o_res        = r_pend;
        o_res.last   = 1'b0;
        // a new result pushes the held one out, which is then not the last
        can_prod     = !r_pend_valid || i_res_ready;

        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_state = i_dir ? ST_DEC_PUT : ST_ENC_PUT;
                end
            end
            ST_ENC_PUT: begin
                if (r_req.data == '0) begin
                    prod           = 1'b1;
                    prod_res.error = 1'b1;
                    if (can_prod) begin
                        n_state = ST_ENC_WORD;
                    end
                end else begin
                    sh_in   = {{(BUF_BITS-CODE_BITS){1'b0}}, enc_code};
                    sh_amt  = enc_amt;
                    n_buf   = r_buf | sh_out;
                    n_cnt   = enc_sum;
                    n_state = ST_ENC_WORD;
                end
            end
            ST_ENC_WORD: begin
                sh_amt = AMT_W'(WORD_BITS);
                if (r_cnt >= CNT_W'(WORD_BITS)) begin
                    prod          = 1'b1;
                    prod_res.data = r_buf[BUF_BITS-1 -: WORD_BITS];
                    prod_res.bits = LEN_W'(WORD_BITS);
                    if (can_prod) begin
                        n_buf = sh_out;
                        n_cnt = r_cnt - CNT_W'(WORD_BITS);
                    end
                end else if (r_req.last && r_cnt != '0) begin
                    // flush the partial word, zero padded
                    prod          = 1'b1;
                    prod_res.data = r_buf[BUF_BITS-1 -: WORD_BITS];
                    prod_res.bits = r_cnt[LEN_W-1:0];
                    if (can_prod) begin
                        n_buf   = '0;
                        n_cnt   = '0;
                        n_state = ST_DRAIN;
                    end
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DEC_PUT: begin
                sh_left = 1'b0;
                sh_in   = {r_req.data, {(BUF_BITS-WORD_BITS){1'b0}}};
                sh_amt  = dec_cnt[AMT_W-1:0];
                n_buf   = dec_buf | sh_out;
                n_cnt   = dec_cnt + CNT_W'(WORD_BITS);
                n_state = ST_DEC_STEP;
            end
            ST_DEC_STEP: begin
                sh_amt = AMT_W'(parse.len);
                case (parse.kind)
                    DEC_OK: begin
                        prod          = 1'b1;
                        prod_res.data = parse.val;
                        prod_res.bits = parse.len;
                        if (can_prod) begin
                            n_buf = sh_out;
                            n_cnt = r_cnt - CNT_W'(parse.len);
                        end
                    end
                    DEC_BAD: begin
                        prod           = 1'b1;
                        prod_res.error = 1'b1;
                        if (can_prod) begin
                            n_buf   = '0;
                            n_cnt   = '0;
                            n_state = ST_DRAIN;
                        end
                    end
                    default: begin
                        // incomplete code waits for the next word unless the stream ends
                        if (r_req.last) begin
                            n_buf = '0;
                            n_cnt = '0;
                        end
                        n_state = ST_DRAIN;
                    end
                endcase
            end
            ST_DRAIN: begin
                if (r_pend_valid) begin
                    o_res_valid = 1'b1;
                    o_res.last  = 1'b1;
                    if (i_res_ready) begin
                        n_pend_valid = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (prod) begin
            o_res_valid = r_pend_valid;
            if (can_prod) begin
                n_pend       = prod_res;
                n_pend_valid = 1'b1;
            end
        end

        if (i_clear) begin
            n_buf = '0;
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_buf        <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_buf        <= n_buf;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_req  <= n_req;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(BUF_BITS))
        else $error("bit count beyond buffer size");

    a_enc_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !i_dir) |-> r_cnt < CNT_W'(WORD_BITS))
        else $error("encoder idle with a full word pending");

    a_tail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_buf << r_cnt) == '0)
        else $error("stale bits past the bit count");

    a_code_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DEC_STEP && parse.kind == DEC_OK)
            |-> (CNT_W'(parse.len) <= r_cnt && parse.len != '0))
        else $error("decoded code longer than pending bits");

endmodule
`default_nettype wire

[hw/rtl/elias_delta_stream_codec_top.sv]
// top level: stream ports, direction register and output register of the codec
// encode: each value is accepted, appended to the bit buffer, sent out as full words, then ended
// decode: each word is accepted, put into the bit buffer, then decoded code by code; a word may yield up to 32 codes
// results pass through the pending result register of the core and then the output register
// the sequencer and the shared barrel shifter take one request at a time
// synchronous active-low reset: encode direction, empty bit buffer, no result pending
`default_nettype none
module elias_delta_stream_codec_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_wdata,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [ed_pkg::WORD_BITS-1:0] s_axis_tdata,  // in_data[31:0]
    input  wire logic                         s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [ed_pkg::TDATA_W-1:0]        m_axis_tdata,  // out_data[31:0], out_bits[37:32]
    output logic                              m_axis_tuser,  // out_error
    output logic                              m_axis_tlast
);
    import ed_pkg::*;

    logic r_dir;
    logic r_out_valid;
    t_res r_out;
    t_req req;
    t_res res;
    logic res_valid;
    logic res_ready;

    assign req.data  = s_axis_tdata;
    assign req.last  = s_axis_tlast;
    assign res_ready = !r_out_valid || m_axis_tready;

    ed_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (i_cfg_we),
        .i_dir       (r_dir),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dir <= i_cfg_wdata;
            end
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_W-WORD_BITS-LEN_W){1'b0}}, r_out.bits, r_out.data};
    assign m_axis_tuser  = r_out.error;
    assign m_axis_tlast  = r_out.last;

endmodule
`default_nettype wire
